// ===== sv/assert_macros.svh =====
// Assertion macros for the sort and threshold filter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define STF_ASSERT(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);
`define STF_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`else
`define STF_ASSERT(lbl, cond, msg)
`define STF_ASSERT_IMP(lbl, ante, cons, msg)
`endif
`endif

// ===== sv/stf_pkg.sv =====
// Package with the types and constants of the sort and threshold filter.
`default_nettype none
package stf_pkg;
	localparam int MAX_RECORDS = 16;
	localparam int SCORE_W = 10;
	localparam int TAG_W = 8;
	localparam int COUNT_W = $clog2(MAX_RECORDS + 1);
	localparam logic [SCORE_W-1:0] THRESHOLD_RESET = SCORE_W'(500);

	typedef struct packed {
		logic               valid;
		logic [SCORE_W-1:0] score;
		logic [TAG_W-1:0]   tag;
	} entry_t;

	typedef struct packed {
		logic               ins;
		logic               shl;
		logic [SCORE_W-1:0] new_score;
		logic [TAG_W-1:0]   new_tag;
	} cell_ctrl_t;

	typedef enum logic {
		ST_LOAD,
		ST_DRAIN
	} state_t;
endpackage
`default_nettype wire

// ===== sv/stf_cell.sv =====
// One cell of the insertion-sorting chain, holding a single record.
`default_nettype none
module stf_cell
	import stf_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire cell_ctrl_t ctrl,
	input  wire logic       prev_keep,
	input  wire entry_t     prev_entry,
	input  wire entry_t     next_entry,
	output logic            keep,
	output entry_t          entry
);
	entry_t entry_q;

	assign keep  = entry_q.valid && (entry_q.score <= ctrl.new_score);
	assign entry = entry_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_q <= '0;
		end else if (ctrl.shl) begin
			entry_q <= next_entry;
		end else if (ctrl.ins && !keep) begin
			if (prev_keep) begin
				entry_q <= '{valid: 1'b1, score: ctrl.new_score, tag: ctrl.new_tag};
			end else begin
				entry_q <= prev_entry;
			end
		end
	end
endmodule
`default_nettype wire

// ===== sv/sort_and_threshold_filter.sv =====
// Top level of the sort and threshold filter with its cell chain and output stage.
// Usage:
// Records enter on the input channel (in_valid, in_stall) one per cycle while
// the block is loading. Each record is inserted into a chain of MAX_RECORDS
// cells that keeps the batch sorted by ascending score, ties in arrival order.
// Records beyond capacity are dropped and the batch is marked as overflowed.
// The transfer of a record with last_record set ends the batch; in_stall is
// then high while the chain drains. The chain drains from its head, record by
// record, with records below keep_threshold skipped silently. Each kept record
// is one result on the output channel; if none is kept a single result with
// none_kept set is given. last_out marks the final result. A stall on the
// output holds the output register and pauses the drain. The next batch may
// load while the final result still waits. After reset the chain is empty, the
// block is loading and keep_threshold is 500. keep_threshold is written through
// cfg_we and cfg_wdata; the user must write it only while idle, since the block
// itself does not enforce this.
`default_nettype none
`include "assert_macros.svh"
module sort_and_threshold_filter
	import stf_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_we,
	input  wire logic [SCORE_W-1:0] cfg_wdata,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [SCORE_W-1:0] score,
	input  wire logic [TAG_W-1:0]   record_tag,
	input  wire logic               last_record,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic [SCORE_W-1:0]      out_score,
	output logic [TAG_W-1:0]        out_tag,
	output logic                    none_kept,
	output logic                    overflowed,
	output logic                    last_out
);
	state_t             state_q, state_d;
	logic [SCORE_W-1:0] threshold_q;
	logic [COUNT_W-1:0] count_q;
	logic               ovf_q;
	logic               out_valid_q;
	logic [SCORE_W-1:0] out_score_q;
	logic [TAG_W-1:0]   out_tag_q;
	logic               none_kept_q;
	logic               ovf_out_q;
	logic               last_out_q;

	cell_ctrl_t ctrl;
	entry_t     cells [MAX_RECORDS];
	logic       keeps [MAX_RECORDS];

	logic in_fire, room, drain_go, head_last, emit, emit_none, emit_last, batch_done;

	assign in_fire  = in_valid && !in_stall;
	assign room     = count_q < COUNT_W'(MAX_RECORDS);
	assign drain_go = (state_q == ST_DRAIN) && (!out_valid_q || !out_stall);
	assign head_last = !cells[1].valid;

	assign ctrl.ins       = in_fire && room;
	assign ctrl.shl       = drain_go && cells[0].valid;
	assign ctrl.new_score = score;
	assign ctrl.new_tag   = record_tag;

	for (genvar i = 0; i < MAX_RECORDS; i++) begin : g_cell
		entry_t prev_e, next_e;
		logic   prev_k;
		if (i == 0) begin : g_first
			assign prev_e = '0;
			assign prev_k = 1'b1;
		end else begin : g_mid
			assign prev_e = cells[i-1];
			assign prev_k = keeps[i-1];
		end
		if (i == MAX_RECORDS - 1) begin : g_end
			assign next_e = '0;
		end else begin : g_inner
			assign next_e = cells[i+1];
		end
		stf_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (ctrl),
			.prev_keep  (prev_k),
			.prev_entry (prev_e),
			.next_entry (next_e),
			.keep       (keeps[i]),
			.entry      (cells[i])
		);
	end

	always_comb begin
		state_d    = state_q;
		in_stall   = 1'b1;
		emit       = 1'b0;
		emit_none  = 1'b0;
		emit_last  = 1'b0;
		batch_done = 1'b0;
		unique case (state_q)
			ST_LOAD: begin
				in_stall = 1'b0;
				if (in_valid && last_record) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (drain_go) begin
					if (!cells[0].valid) begin
						emit       = 1'b1;
						emit_none  = 1'b1;
						emit_last  = 1'b1;
						batch_done = 1'b1;
					end else if (cells[0].score >= threshold_q) begin
						emit       = 1'b1;
						emit_last  = head_last;
						batch_done = head_last;
					end else if (head_last) begin
						emit       = 1'b1;
						emit_none  = 1'b1;
						emit_last  = 1'b1;
						batch_done = 1'b1;
					end
				end
				if (batch_done) begin
					state_d = ST_LOAD;
				end
			end
			default: state_d = ST_LOAD;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= THRESHOLD_RESET;
		end else if (cfg_we) begin
			threshold_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			ovf_q   <= 1'b0;
		end else if (batch_done) begin
			count_q <= '0;
			ovf_q   <= 1'b0;
		end else if (in_fire) begin
			if (room) begin
				count_q <= count_q + COUNT_W'(1);
			end else begin
				ovf_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_score_q <= emit_none ? '0 : cells[0].score;
			out_tag_q   <= emit_none ? '0 : cells[0].tag;
			none_kept_q <= emit_none;
			ovf_out_q   <= ovf_q;
			last_out_q  <= emit_last;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_score  = out_score_q;
	assign out_tag    = out_tag_q;
	assign none_kept  = none_kept_q;
	assign overflowed = ovf_out_q;
	assign last_out   = last_out_q;

	`STF_ASSERT(a_count_bound, count_q <= COUNT_W'(MAX_RECORDS), "record count beyond capacity")
	`STF_ASSERT_IMP(a_none_is_last, out_valid && none_kept, last_out, "empty result not final")
	`STF_ASSERT_IMP(a_head_sorted, cells[1].valid,
		cells[0].valid && (cells[0].score <= cells[1].score), "cell chain out of order")
	`STF_ASSERT_IMP(a_no_load_in_drain, state_q == ST_DRAIN, !ctrl.ins,
		"insertion while draining")
endmodule
`default_nettype wire

// ===== sim/sort_and_threshold_filter_test.sv =====
// Self-checking testbench for the sort and threshold filter: batches in, sorted kept records out.
`timescale 1ns / 100ps
module sort_and_threshold_filter_test;
	import stf_pkg::*;

	localparam int TOTAL_ITEMS    = 420;
	localparam int HOLD_CYCLES    = 80;
	localparam int SETTLE_CYCLES  = 6;
	localparam int END_CYCLES     = 40;
	localparam int WATCHDOG_LIMIT = 4000;

	typedef struct packed {
		logic [SCORE_W-1:0] score;
		logic [TAG_W-1:0]   tag;
		logic               none;
		logic               ovf;
		logic               last;
	} kept_result_t;

	class sorted_batch_predictor;
		logic [SCORE_W-1:0] held_score[MAX_RECORDS];
		logic [TAG_W-1:0]   held_tag[MAX_RECORDS];
		int unsigned        held_count;
		bit                 spilled;
		logic [SCORE_W-1:0] threshold;
		kept_result_t       due[$];
		int unsigned        mismatches;
		int unsigned        checked;
		int unsigned        batches;
		int unsigned        spilled_batches;
		int unsigned        empty_batches;

		function new();
			threshold = THRESHOLD_RESET;
			held_count = 0;
			spilled = 0;
			mismatches = 0;
			checked = 0;
			batches = 0;
			spilled_batches = 0;
			empty_batches = 0;
		endfunction

		function void note_record(logic [SCORE_W-1:0] sc, logic [TAG_W-1:0] tg, logic last);
			logic [SCORE_W-1:0] s;
			logic [TAG_W-1:0]   t;
			int                 j;
			int unsigned        kept;
			kept_result_t       r;
			if (held_count < MAX_RECORDS) begin
				held_score[held_count] = sc;
				held_tag[held_count] = tg;
				held_count++;
			end else begin
				spilled = 1'b1;
			end
			if (!last)
				return;
			// A strict comparison keeps equal scores in arrival order.
			for (int i = 1; i < held_count; i++) begin
				s = held_score[i];
				t = held_tag[i];
				j = i;
				while (j > 0 && held_score[j-1] > s) begin
					held_score[j] = held_score[j-1];
					held_tag[j] = held_tag[j-1];
					j--;
				end
				held_score[j] = s;
				held_tag[j] = t;
			end
			kept = 0;
			for (int i = 0; i < held_count; i++) begin
				if (held_score[i] >= threshold) begin
					r = '0;
					r.score = held_score[i];
					r.tag = held_tag[i];
					r.ovf = spilled;
					due.push_back(r);
					kept++;
				end
			end
			if (kept == 0) begin
				r = '0;
				r.none = 1'b1;
				r.ovf = spilled;
				due.push_back(r);
				empty_batches++;
			end
			due[due.size()-1].last = 1'b1;
			batches++;
			if (spilled)
				spilled_batches++;
			held_count = 0;
			spilled = 1'b0;
		endfunction

		function void compare_field(string name, logic [31:0] want, logic [31:0] got);
			if (got !== want) begin
				$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
				mismatches++;
			end
		endfunction

		function void check_result(kept_result_t got);
			kept_result_t want;
			if (due.size() == 0) begin
				$display("%0t: unexpected result, expected none, got score %0d tag %0d none_kept %0b overflowed %0b last_out %0b",
					$time, got.score, got.tag, got.none, got.ovf, got.last);
				mismatches++;
				return;
			end
			want = due.pop_front();
			checked++;
			compare_field("out_score", want.score, got.score);
			compare_field("out_tag", want.tag, got.tag);
			compare_field("none_kept", want.none, got.none);
			compare_field("overflowed", want.ovf, got.ovf);
			compare_field("last_out", want.last, got.last);
		endfunction
	endclass

	logic               clk;
	logic               arst_n = 1'b0;
	logic               cfg_we = 1'b0;
	logic [SCORE_W-1:0] cfg_wdata = '0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic [SCORE_W-1:0] score = '0;
	logic [TAG_W-1:0]   record_tag = '0;
	logic               last_record = 1'b0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [SCORE_W-1:0] out_score;
	logic [TAG_W-1:0]   out_tag;
	logic               none_kept;
	logic               overflowed;
	logic               last_out;

	sorted_batch_predictor predictor = new();
	int unsigned records_sent = 0;
	int unsigned threshold_writes = 0;
	int unsigned send_gap_odds = 0;
	int unsigned recv_gap_odds = 0;
	bit          hold_req = 1'b0;
	int unsigned quiet_cycles = 0;

	sort_and_threshold_filter u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.score      (score),
		.record_tag (record_tag),
		.last_record(last_record),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_score  (out_score),
		.out_tag    (out_tag),
		.none_kept  (none_kept),
		.overflowed (overflowed),
		.last_out   (last_out)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	task automatic send_record(logic [SCORE_W-1:0] sc, logic [TAG_W-1:0] tg, logic last);
		int unsigned burst;
		if (send_gap_odds != 0 && $urandom_range(0, send_gap_odds) == 0) begin
			burst = $urandom_range(1, 17);
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (burst - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid <= 1'b1;
		score <= sc;
		record_tag <= tg;
		last_record <= last;
		do @(posedge clk); while (in_stall !== 1'b0);
		predictor.note_record(sc, tg, last);
		records_sent++;
	endtask

	task automatic wait_settled();
		@(negedge clk);
		in_valid <= 1'b0;
		while (predictor.due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_threshold(logic [SCORE_W-1:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		predictor.threshold = value;
		threshold_writes++;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic logic [SCORE_W-1:0] pick_score();
		case ($urandom_range(0, 4))
			0: return SCORE_W'(predictor.threshold + $urandom_range(0, 2) - 1);
			1: return SCORE_W'(100 * $urandom_range(0, 10));
			2: return SCORE_W'($urandom_range(990, 1023));
			default: return SCORE_W'($urandom_range(0, 1023));
		endcase
	endfunction

	task automatic run_batch();
		int unsigned len;
		len = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 22) : $urandom_range(1, 16);
		for (int i = 0; i < len; i++)
			send_record(pick_score(), TAG_W'($urandom_range(0, 255)), i == len - 1);
	endtask

	// The receiver stalls in random bursts and once for a long stretch to back up the block.
	initial begin
		int unsigned stall_left;
		stall_left = 0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				stall_left = HOLD_CYCLES;
			end else if (stall_left == 0 && recv_gap_odds != 0
					&& $urandom_range(0, recv_gap_odds) == 0) begin
				stall_left = $urandom_range(1, 17);
			end
			if (stall_left > 0) begin
				out_stall <= 1'b1;
				stall_left--;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (out_valid === 1'b1 && out_stall === 1'b0)
			predictor.check_result('{out_score, out_tag, none_kept, overflowed, last_out});
	end

	always @(posedge clk) begin
		if ((in_valid === 1'b1 && in_stall === 1'b0) || (out_valid === 1'b1 && out_stall === 1'b0))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no transfer for %0d cycles, %0d results still expected",
				$time, WATCHDOG_LIMIT, predictor.due.size());
			$display("[sort_and_threshold_filter] ERROR");
			$finish;
		end
	end

	initial begin
		int unsigned phase;
		int unsigned phase_start;
		logic [SCORE_W-1:0] level;
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;

		// Ties at the threshold, a record just below it, and a high score of 1000.
		send_record(SCORE_W'(500), 8'h00, 1'b0);
		send_record(SCORE_W'(499), 8'hFF, 1'b0);
		send_record(SCORE_W'(1000), 8'h5A, 1'b0);
		send_record(SCORE_W'(500), 8'hA5, 1'b1);
		// A lone record below the threshold leaves nothing kept.
		send_record(SCORE_W'(0), 8'h01, 1'b1);
		// One record too many: the dropped record still ends the batch.
		for (int i = 0; i < MAX_RECORDS + 1; i++)
			send_record(SCORE_W'(1023 - 61 * i), TAG_W'(i), i == MAX_RECORDS);

		phase = 0;
		while (records_sent < TOTAL_ITEMS) begin
			wait_settled();
			case (phase)
				0: level = SCORE_W'(0);
				1: level = SCORE_W'(1000);
				2: level = SCORE_W'(1023);
				3: level = THRESHOLD_RESET;
				default: level = SCORE_W'($urandom_range(0, 1023));
			endcase
			write_threshold(level);
			if (records_sent + 60 >= TOTAL_ITEMS) begin
				send_gap_odds = 0;
				recv_gap_odds = 0;
			end else begin
				send_gap_odds = (phase % 3 == 2) ? 0 : $urandom_range(2, 6);
				recv_gap_odds = (phase % 4 == 3) ? 0 : $urandom_range(2, 6);
			end
			if (phase == 1)
				hold_req = 1'b1;
			phase_start = records_sent;
			while (records_sent - phase_start < 50 && records_sent < TOTAL_ITEMS)
				run_batch();
			phase++;
		end

		wait_settled();
		repeat (END_CYCLES) @(posedge clk);
		$display("Sent %0d records in %0d batches under %0d threshold settings.",
			records_sent, predictor.batches, threshold_writes + 1);
		$display("Checked %0d results; %0d batches overflowed, %0d kept nothing.",
			predictor.checked, predictor.spilled_batches, predictor.empty_batches);
		if (predictor.mismatches == 0 && predictor.due.size() == 0) begin
			$display("[sort_and_threshold_filter] OK");
		end else begin
			$display("[sort_and_threshold_filter] ERROR");
		end
		$finish;
	end
endmodule

// ===== files.f =====
+incdir+sv
sv/stf_pkg.sv
sv/stf_cell.sv
sv/sort_and_threshold_filter.sv
sim/sort_and_threshold_filter_test.sv
